@@ sv/aarm_pkg.sv @@
// ----------------------------------------------------------------------------
// aarm_pkg
// Constants shared by the axis-angle rotation matrix core.
// ----------------------------------------------------------------------------
package aarm_pkg;

  localparam int WORK_BITS = 30;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] t;
    unique case (k & 31)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return t;
  endfunction

endpackage

@@ sv/axis_angle_rotation_matrix_core.sv @@
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// Binary angle and axis in, nine Q1.FRAC_BITS rotation matrix entries out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per handshake: angle, axis_x, axis_y, axis_z.
//   m_axis returns the nine entries r00..r22 in row order, one per request.
//   Throughput is one request per cycle while the output is not stalled: the
//   input register, the CORDIC stages, the rounding stage and five
//   multiply/sum/clamp stages each hold one request.
//   The whole pipeline advances together; when m_axis_tready is low and the
//   output stage is full, every stage holds and s_axis_tready drops, so
//   nothing is lost or repeated. Bubbles are not squeezed out during a stall.
//   rst clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core #(
  parameter int ANGLE_BITS    = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // angle, axis_x, axis_y, axis_z (lowest bit first)
  input  logic [((ANGLE_BITS+3*(FRAC_BITS+2)+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (lowest bit first)
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  import aarm_pkg::*;

  localparam int DW = FRAC_BITS + 2;
  localparam int NS = CORDIC_STAGES;
  localparam int SH = WORK_BITS - FRAC_BITS;
  localparam int PW = 2 * DW + 2;
  localparam int PN = DW + 2;
  localparam int MW2 = 2 * PW;
  localparam int OW = ((9*DW+7)/8)*8;
  localparam logic signed [PW-1:0] ONE_Q = PW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] LIM4 = (PW'(4) <<< FRAC_BITS) - PW'(1);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CW-1:0] CHALF = (CW'(1) <<< SH) >>> 1;

  function automatic logic signed [PW-1:0] clamp(input logic signed [PW-1:0] v,
                                                  input logic signed [PW-1:0] l);
    logic signed [PW-1:0] r;
    if (v > l) r = l;
    else if (v < -l) r = -l;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [PW-1:0] rnd(input logic signed [MW2-1:0] v);
    logic signed [MW2-1:0] t;
    t = (v + MW2'(HALF)) >>> FRAC_BITS;
    return PW'(t);
  endfunction

  // narrow signed product, rounded half up to Q FRAC_BITS
  function automatic logic signed [PW-1:0] mul_rnd(input logic signed [PN-1:0] a,
                                                    input logic signed [PN-1:0] b);
    logic signed [2*PN-1:0] m;
    m = a * b;
    return rnd(MW2'(m));
  endfunction

  logic adv;
  logic [NS+6:0] vld;
  assign m_axis_tvalid = vld[NS+6];
  assign adv = !vld[NS+6] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS+5:0], s_axis_tvalid};
    end
  end

  // CORDIC
  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [CW-1:0] cz [NS];
  logic [1:0] cq [NS+1];
  logic signed [DW-1:0] ax [NS+3];
  logic signed [DW-1:0] ay [NS+3];
  logic signed [DW-1:0] az [NS+3];

  logic [31:0] turns;
  assign turns = {s_axis_tdata[ANGLE_BITS-1:0], (32-ANGLE_BITS)'(0)};

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CORDIC_X0;
      cy[0] <= '0;
      cz[0] <= CW'({2'b00, turns[29:0]});
      cq[0] <= turns[31:30];
      ax[0] <= s_axis_tdata[ANGLE_BITS +: DW];
      ay[0] <= s_axis_tdata[ANGLE_BITS+DW +: DW];
      az[0] <= s_axis_tdata[ANGLE_BITS+2*DW +: DW];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam int K = i % 32;
    localparam logic signed [CW-1:0] AT = CW'(atan_turn(K));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][CW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> K);
          cy[i+1] <= cy[i] + (cx[i] >>> K);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> K);
          cy[i+1] <= cy[i] - (cx[i] >>> K);
        end
        cq[i+1] <= cq[i];
        ax[i+1] <= ax[i];
        ay[i+1] <= ay[i];
        az[i+1] <= az[i];
      end
    end
    if (i < NS-1) begin : g_z
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!cz[i][CW-1]) begin
            cz[i+1] <= cz[i] - AT;
          end else begin
            cz[i+1] <= cz[i] + AT;
          end
        end
      end
    end
  end

  for (genvar j = NS; j < NS+2; j++) begin : g_axdly
    always_ff @(posedge clk) begin
      if (adv) begin
        ax[j+1] <= ax[j];
        ay[j+1] <= ay[j];
        az[j+1] <= az[j];
      end
    end
  end

  // quadrant map and rounding
  logic signed [CW-1:0] cw, sw;
  always_comb begin
    unique case (cq[NS])
      2'd0: begin cw = cx[NS];  sw = cy[NS];  end
      2'd1: begin cw = -cy[NS]; sw = cx[NS];  end
      2'd2: begin cw = -cx[NS]; sw = -cy[NS]; end
      default: begin cw = cy[NS]; sw = -cx[NS]; end
    endcase
  end

  logic signed [CW-1:0] cr, sr;
  assign cr = (cw + CHALF) >>> SH;
  assign sr = (sw + CHALF) >>> SH;

  logic signed [PW-1:0] c1, s1, omc1;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= clamp(PW'(cr), ONE_Q);
      s1 <= clamp(PW'(sr), ONE_Q);
      omc1 <= ONE_Q - clamp(PW'(cr), ONE_Q);
    end
  end

  // axis products: xx yy zz xy xz yz
  logic signed [PW-1:0] p2 [6];
  logic signed [PW-1:0] c2, s2, omc2, c3, c4;
  logic signed [PW-1:0] sx3, sy3, sz3, sx4, sy4, sz4;
  logic signed [PW-1:0] t3 [6];
  logic signed [PW-1:0] t4 [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      p2[0] <= clamp(mul_rnd(PN'(ax[NS+1]), PN'(ax[NS+1])), LIM4);
      p2[1] <= clamp(mul_rnd(PN'(ay[NS+1]), PN'(ay[NS+1])), LIM4);
      p2[2] <= clamp(mul_rnd(PN'(az[NS+1]), PN'(az[NS+1])), LIM4);
      p2[3] <= clamp(mul_rnd(PN'(ax[NS+1]), PN'(ay[NS+1])), LIM4);
      p2[4] <= clamp(mul_rnd(PN'(ax[NS+1]), PN'(az[NS+1])), LIM4);
      p2[5] <= clamp(mul_rnd(PN'(ay[NS+1]), PN'(az[NS+1])), LIM4);
      c2 <= c1; s2 <= s1; omc2 <= omc1;
      for (int k = 0; k < 6; k++) t3[k] <= mul_rnd(PN'(p2[k]), PN'(omc2));
      sx3 <= mul_rnd(PN'(ax[NS+2]), PN'(s2));
      sy3 <= mul_rnd(PN'(ay[NS+2]), PN'(s2));
      sz3 <= mul_rnd(PN'(az[NS+2]), PN'(s2));
      c3 <= c2;
      t4 <= t3; sx4 <= sx3; sy4 <= sy3; sz4 <= sz3; c4 <= c3;
    end
  end

  logic signed [PW-1:0] r5 [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      r5[0] <= c4 + t4[0];
      r5[1] <= t4[3] + sz4;
      r5[2] <= t4[4] - sy4;
      r5[3] <= t4[3] - sz4;
      r5[4] <= c4 + t4[1];
      r5[5] <= t4[5] + sx4;
      r5[6] <= t4[4] + sy4;
      r5[7] <= t4[5] - sx4;
      r5[8] <= c4 + t4[2];
    end
  end

  logic [9*DW-1:0] packed_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) packed_r[k*DW +: DW] <= DW'(clamp(r5[k], ONE_Q));
    end
  end
  assign m_axis_tdata = OW'(packed_r);
endmodule

@@ sv/aarm_checker.sv @@
// ----------------------------------------------------------------------------
// aarm_checker
// Port-level checks on the rotation matrix core.
// ----------------------------------------------------------------------------
module aarm_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready) else $error("stalled without back-pressure");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("took request in stall");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (.*);

@@ tb/tb_axis_angle_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix_core
// Streams angle/axis requests through the core, checks four directed results
// against identity and the rest against a bit-exact CORDIC and fixed-point
// predictor, under sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_axis_angle_rotation_matrix_core;
  import aarm_pkg::CORDIC_X0;

  localparam int AB = 16;
  localparam int FB = 14;
  localparam int STAGES = 16;
  localparam int DB = FB + 2;
  localparam int SW = ((AB + 3*DB + 7)/8)*8;
  localparam int MW = ((9*DB + 7)/8)*8;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LAT = STAGES + 6;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [DB-1:0] z;
    logic signed [DB-1:0] y;
    logic signed [DB-1:0] x;
    logic [AB-1:0]        angle;
  } req_t;

  typedef logic [MW-1:0] mat_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [SW-1:0] s_axis_tdata;
  logic [MW-1:0] m_axis_tdata;

  axis_angle_rotation_matrix_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  mat_t matrix_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint clampv(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint scaled_prod(longint u, longint v, longint omc);
    longint p;
    p = clampv(rshift(u * v, FB), 4 * ONE - 1);
    return rshift(p * omc, FB);
  endfunction

  function automatic mat_t rotation_matrix(req_t r);
    logic [31:0] turns;
    longint cx, cy, cz, dx, dy, cw, sw, c, s, omc, ax, ay, az;
    longint e[9];
    mat_t m;
    turns = {r.angle, 16'h0};
    cx = CORDIC_X0;
    cy = 0;
    cz = longint'(turns[29:0]);
    for (int i = 0; i < STAGES; i++) begin
      dx = fshift(cy, i % 32);
      dy = fshift(cx, i % 32);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= longint'(aarm_pkg::atan_turn(i));
      end else begin
        cx += dx; cy -= dy; cz += longint'(aarm_pkg::atan_turn(i));
      end
    end
    case (turns[31:30])
      2'd0: begin cw = cx; sw = cy; end
      2'd1: begin cw = -cy; sw = cx; end
      2'd2: begin cw = -cx; sw = -cy; end
      default: begin cw = cy; sw = -cx; end
    endcase
    c = clampv(rshift(cw, 30 - FB), ONE);
    s = clampv(rshift(sw, 30 - FB), ONE);
    omc = ONE - c;
    ax = r.x; ay = r.y; az = r.z;
    e[0] = c + scaled_prod(ax, ax, omc);
    e[1] = scaled_prod(ax, ay, omc) + rshift(az * s, FB);
    e[2] = scaled_prod(ax, az, omc) - rshift(ay * s, FB);
    e[3] = scaled_prod(ax, ay, omc) - rshift(az * s, FB);
    e[4] = c + scaled_prod(ay, ay, omc);
    e[5] = scaled_prod(ay, az, omc) + rshift(ax * s, FB);
    e[6] = scaled_prod(ax, az, omc) + rshift(ay * s, FB);
    e[7] = scaled_prod(ay, az, omc) - rshift(ax * s, FB);
    e[8] = c + scaled_prod(az, az, omc);
    m = '0;
    for (int k = 0; k < 9; k++) m[k*DB +: DB] = DB'(clampv(e[k], ONE));
    return m;
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    mat_t want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected matrix %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = matrix_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata[k*DB +: DB] !== want[k*DB +: DB]) begin
              $display("%0t: entry r%0d%0d expected %h got %h", $time, k / 3, k % 3,
                       want[k*DB +: DB], m_axis_tdata[k*DB +: DB]);
              errors++;
            end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // one request; expected matrix is queued on acceptance
  task automatic send_request(req_t r, bit use_fixed, mat_t fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= SW'(r);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    matrix_q.push_back(use_fixed ? fixed : rotation_matrix(r));
  endtask

  function automatic logic signed [DB-1:0] rand_comp();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return DB'($urandom);
      default: return DB'($urandom_range(32768) - 16384);
    endcase
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  localparam mat_t IDENT = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                            16'sd0, 16'sd0, 16'sd0, 16'sd16384};

  req_t dir_tab[20];
  bit   dir_fixed[20];
  req_t r;

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    dir_tab[0]  = '{16'sd16384, 16'sd0, 16'sd0, 16'h0000};
    dir_tab[1]  = '{16'sd0, 16'sd16384, 16'sd0, 16'h0000};
    dir_tab[2]  = '{16'sd0, 16'sd0, 16'sd16384, 16'h0000};
    dir_tab[3]  = '{16'sd16384, 16'sd0, 16'sd0, 16'h4000};
    dir_tab[4]  = '{16'sd16384, 16'sd0, 16'sd0, 16'h8000};
    dir_tab[5]  = '{16'sd16384, 16'sd0, 16'sd0, 16'hC000};
    dir_tab[6]  = '{16'sd16384, 16'sd0, 16'sd0, 16'hFFFF};
    dir_tab[7]  = '{-16'sd16384, -16'sd16384, -16'sd16384, 16'h2000};
    dir_tab[8]  = '{-16'sd32768, -16'sd32768, -16'sd32768, 16'h8000};
    dir_tab[9]  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'h6000};
    dir_tab[10] = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'hA000};
    dir_tab[11] = '{16'sd9459, 16'sd9459, 16'sd9459, 16'h1555};
    dir_tab[12] = '{16'sd0, 16'sd0, 16'sd0, 16'h4000};
    dir_tab[13] = '{16'sd11585, -16'sd11585, 16'sd0, 16'h0001};
    dir_tab[14] = '{-16'sd1, 16'sd1, -16'sd1, 16'h7FFF};
    dir_tab[15] = '{16'sd16384, 16'sd16384, 16'sd16384, 16'hE000};
    dir_tab[16] = '{-16'sd32768, 16'sd0, 16'sd0, 16'hFFFF};
    dir_tab[17] = '{16'sd5461, 16'sd13653, -16'sd8192, 16'h9999};
    dir_tab[18] = '{16'sd16384, 16'sd0, 16'sd0, 16'h0000};
    dir_tab[19] = '{16'sd0, 16'sd0, 16'sd0, 16'h8001};
    foreach (dir_fixed[i]) dir_fixed[i] = (i <= 2) || (i == 18);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) send_request(dir_tab[i], dir_fixed[i], IDENT);
    drain();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < 480; n++) begin
        r.angle = (n % 7 == 0) ? 16'(($urandom_range(7)) << 13) : 16'($urandom);
        r.x = rand_comp();
        r.y = rand_comp();
        r.z = rand_comp();
        if (ph == 0 && n == 100) begin
          hold_off = 1;
          fork
            begin repeat (300) @(posedge clk); hold_off = 0; end
          join_none
        end
        send_request(r, 0, '0);
      end
      drain();
    end

    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ axis_angle_rotation_matrix_core.f @@
sv/aarm_pkg.sv
sv/axis_angle_rotation_matrix_core.sv
sv/aarm_checker.sv
tb/tb_axis_angle_rotation_matrix_core.sv
